// ===== rtl/core/fobh_pkg.sv =====
// shared types, constants and arithmetic helpers for the heun step core
package fobh_pkg;

    localparam int FRAC_BITS = 16;
    localparam int W         = 32;
    localparam int DIV_W     = W + FRAC_BITS;

    localparam logic signed [W-1:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [W-1:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [W-1:0] SLOPE_LOW_RST  = -32'sd65536000;
    localparam logic signed [W-1:0] SLOPE_HIGH_RST = 32'sd65536000;

    typedef enum logic [2:0] {
        OP_PREDICT     = 3'd0,
        OP_CORRECT     = 3'd1,
        OP_PREDICT_CPY = 3'd2,
        OP_CORRECT_CPY = 3'd3,
        OP_INIT_IN     = 3'd4,
        OP_INIT_OUT    = 3'd5,
        OP_QUERY6      = 3'd6,
        OP_QUERY7      = 3'd7
    } t_opcode;

    typedef enum logic [2:0] {
        CFG_COEF_STATE = 3'd0,
        CFG_COEF_INPUT = 3'd1,
        CFG_COEF_FEED  = 3'd2,
        CFG_SLOPE_LOW  = 3'd3,
        CFG_SLOPE_HIGH = 3'd4
    } t_cfg_index;

    typedef struct packed {
        logic [2:0]          opcode;
        logic signed [31:0]  in_value;
        logic [30:0]         step_time;
        logic signed [31:0]  x_low;
        logic signed [31:0]  x_high;
        logic signed [31:0]  y_low;
        logic signed [31:0]  y_high;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] out_value;
        logic signed [31:0] state_value;
        logic               div_error;
    } t_out_word;

    // multiplier operand select
    typedef enum logic [2:0] {
        MS_AX, MS_BU, MS_DU, MS_DTD, MS_NRU, MS_NRY
    } t_mul_sel;

    // adder / post step select
    typedef enum logic [3:0] {
        AS_NONE, AS_SLOPE, AS_PRED, AS_CORR_SUM, AS_CORR, AS_OUT, AS_NEGR,
        AS_DEN, AS_STATE_IN, AS_Y_IN, AS_STATE_OUT
    } t_add_sel;

    typedef enum logic [1:0] {
        DS_BA, DS_UDEN
    } t_div_sel;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DECODE, ST_MUL, ST_ADD, ST_DIV_START, ST_DIV_WAIT, ST_DIV_POST,
        ST_FINISH, ST_OUT
    } t_state;

    typedef struct packed {
        logic     load;
        logic     mul_go;
        t_mul_sel mul_sel;
        logic     add_go;
        t_add_sel add_sel;
        logic     div_go;
        t_div_sel div_sel;
        logic     div_post;
        logic     commit;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic [2:0] opcode;
        logic       a_zero;
        logic       b_zero;
        logic       den_zero;
        logic       div_done;
    } t_sts;

    function automatic logic signed [W-1:0] sat64(input logic signed [63:0] v);
        logic signed [W-1:0] r;
        if (v > 64'(signed'(Q_MAX))) r = Q_MAX;
        else if (v < 64'(signed'(Q_MIN))) r = Q_MIN;
        else r = v[W-1:0];
        return r;
    endfunction

    function automatic logic signed [W-1:0] clampv(input logic signed [W-1:0] v,
            input logic signed [W-1:0] lo, input logic signed [W-1:0] hi);
        logic signed [W-1:0] r;
        r = (v > hi) ? hi : v;
        if (r < lo) r = lo;
        return r;
    endfunction

endpackage

// ===== rtl/core/fobh_div.sv =====
// restoring divider: signed numerator scaled by 2^frac over a signed divisor
module fobh_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_go,
    input  logic signed [fobh_pkg::W-1:0]  i_num,
    input  logic signed [fobh_pkg::W-1:0]  i_den,
    output logic                           o_done,
    output logic signed [fobh_pkg::W-1:0]  o_quot
);
    localparam int DW = fobh_pkg::DIV_W;
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] r_q, n_q;
    logic [DW:0]   r_rem, n_rem;
    logic [fobh_pkg::W-1:0] r_den;
    logic          r_neg;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   trial;

    always_comb begin
        trial = {r_rem[DW-1:0], r_q[DW-1]} - {{(DW-fobh_pkg::W+1){1'b0}}, r_den};
        if (!trial[DW]) begin
            n_rem = trial;
            n_q   = {r_q[DW-2:0], 1'b1};
        end else begin
            n_rem = {r_rem[DW-1:0], r_q[DW-1]};
            n_q   = {r_q[DW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_q   <= {(i_num[fobh_pkg::W-1] ? -{{(DW-fobh_pkg::W){i_num[fobh_pkg::W-1]}}, i_num}
                      : {{(DW-fobh_pkg::W){1'b0}}, i_num})} << fobh_pkg::FRAC_BITS;
            r_rem <= '0;
            r_den <= i_den[fobh_pkg::W-1] ? -i_den : i_den;
            r_neg <= i_num[fobh_pkg::W-1] ^ i_den[fobh_pkg::W-1];
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    logic signed [63:0] sq;
    always_comb begin
        sq = r_neg ? -$signed({16'd0, r_q}) : $signed({16'd0, r_q});
        o_quot = fobh_pkg::sat64(sq);
    end
    assign o_done = r_done;
endmodule

// ===== rtl/core/fobh_datapath.sv =====
// datapath: registers, state, one multiplier, saturating adder and divider
module fobh_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [2:0]                     i_cfg_index,
    input  logic [31:0]                    i_cfg_data,
    input  fobh_pkg::t_in_word             i_word,
    input  fobh_pkg::t_cmd                 i_cmd,
    output fobh_pkg::t_sts                 o_sts,
    output fobh_pkg::t_out_word            o_word
);
    localparam int W = fobh_pkg::W;
    localparam int FB = fobh_pkg::FRAC_BITS;

    logic signed [W-1:0] r_a, r_b, r_d, r_slo, r_shi;
    logic signed [W-1:0] r_x, r_px, r_ps;
    logic                r_stage;
    fobh_pkg::t_in_word  r_in;
    logic signed [W-1:0] r_prod, r_acc, r_t0, r_nr, r_y, r_xn;
    logic                r_err;
    fobh_pkg::t_out_word r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a   <= '0;
            r_b   <= '0;
            r_d   <= '0;
            r_slo <= fobh_pkg::SLOPE_LOW_RST;
            r_shi <= fobh_pkg::SLOPE_HIGH_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                fobh_pkg::CFG_COEF_STATE: r_a   <= i_cfg_data;
                fobh_pkg::CFG_COEF_INPUT: r_b   <= i_cfg_data;
                fobh_pkg::CFG_COEF_FEED:  r_d   <= i_cfg_data;
                fobh_pkg::CFG_SLOPE_LOW:  r_slo <= i_cfg_data;
                fobh_pkg::CFG_SLOPE_HIGH: r_shi <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // multiplier operands
    logic signed [W-1:0] ma, mb;
    logic signed [63:0]  mp, msh;
    always_comb begin
        ma = r_a;
        mb = r_x;
        unique case (i_cmd.mul_sel)
            fobh_pkg::MS_AX:  begin ma = r_a;  mb = r_in.opcode == fobh_pkg::OP_CORRECT ? r_px : r_x; end
            fobh_pkg::MS_BU:  begin ma = r_b;  mb = r_in.in_value; end
            fobh_pkg::MS_DU:  begin ma = r_d;  mb = r_in.in_value; end
            fobh_pkg::MS_DTD: begin ma = $signed({1'b0, r_in.step_time}); mb = r_acc; end
            fobh_pkg::MS_NRU: begin ma = r_nr; mb = r_in.in_value; end
            fobh_pkg::MS_NRY: begin ma = r_nr; mb = r_y; end
            default: ;
        endcase
        mp  = 64'(ma) * 64'(mb);
        msh = mp >>> FB;
    end

    // divider
    logic                div_done;
    logic signed [W-1:0] div_q;
    fobh_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.div_go),
        .i_num   (i_cmd.div_sel == fobh_pkg::DS_BA ? r_b : r_in.in_value),
        .i_den   (i_cmd.div_sel == fobh_pkg::DS_BA ? r_a : r_acc),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    logic signed [W:0]   sum;
    logic signed [W-1:0] ss, half;
    always_comb begin
        sum  = 33'(r_ps) + 33'(r_acc);
        half = W'(sum >>> 1);
        ss   = fobh_pkg::sat64(64'(r_t0) + 64'(r_prod));
    end

    logic signed [63:0] nr64, den64;
    always_comb begin
        nr64  = -64'(div_q);
        den64 = 64'(r_d) - 64'(div_q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x     <= '0;
            r_px    <= '0;
            r_ps    <= '0;
            r_stage <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_in  <= i_word;
                r_err <= 1'b0;
            end
            if (i_cmd.mul_go) r_prod <= fobh_pkg::sat64(msh);
            if (i_cmd.div_post) begin
                if (i_cmd.div_sel == fobh_pkg::DS_BA) begin
                    r_nr <= fobh_pkg::sat64(nr64);
                    r_acc <= fobh_pkg::sat64(den64);
                end else begin
                    r_y <= div_q;
                end
            end
            if (i_cmd.add_go) begin
                unique case (i_cmd.add_sel)
                    fobh_pkg::AS_NONE:  r_t0 <= r_prod;
                    fobh_pkg::AS_SLOPE: r_acc <= ss;
                    fobh_pkg::AS_PRED:  r_acc <= fobh_pkg::clampv(r_acc, r_slo, r_shi);
                    fobh_pkg::AS_CORR_SUM: r_acc <= fobh_pkg::clampv(half, r_slo, r_shi);
                    fobh_pkg::AS_CORR:  r_xn <= fobh_pkg::clampv(
                            fobh_pkg::sat64(64'(r_x) + 64'(r_prod)), r_in.x_low, r_in.x_high);
                    fobh_pkg::AS_OUT:   r_y <= fobh_pkg::clampv(
                            fobh_pkg::sat64(64'(r_xn) + 64'(r_prod)), r_in.y_low, r_in.y_high);
                    fobh_pkg::AS_STATE_IN: r_xn <= r_prod;
                    fobh_pkg::AS_Y_IN:  r_y <= fobh_pkg::sat64(64'(r_xn) + 64'(r_prod));
                    fobh_pkg::AS_STATE_OUT: r_xn <= r_prod;
                    fobh_pkg::AS_NEGR: begin
                        // zero divisor saturates by sign of y
                        r_err <= 1'b1;
                        r_y <= (r_in.in_value > 0) ? fobh_pkg::Q_MAX :
                               (r_in.in_value < 0) ? fobh_pkg::Q_MIN : '0;
                    end
                    fobh_pkg::AS_DEN: begin
                        // prepare query / copy / a-zero and b-zero init paths
                        unique case (r_in.opcode)
                            fobh_pkg::OP_PREDICT_CPY: r_xn <= r_x;
                            fobh_pkg::OP_CORRECT_CPY: r_xn <= r_px;
                            fobh_pkg::OP_INIT_IN: begin r_xn <= '0; r_y <= r_prod; end
                            fobh_pkg::OP_INIT_OUT: begin r_xn <= r_in.in_value; r_y <= '0; end
                            default: r_xn <= r_stage ? r_px : r_x;
                        endcase
                    end
                    default: ;
                endcase
            end
            if (i_cmd.commit) begin
                unique case (r_in.opcode)
                    fobh_pkg::OP_PREDICT: begin
                        r_ps <= r_acc; r_px <= r_xn; r_stage <= 1'b1;
                    end
                    fobh_pkg::OP_CORRECT: begin
                        r_x <= r_xn; r_stage <= 1'b0;
                    end
                    fobh_pkg::OP_PREDICT_CPY: r_px <= r_xn;
                    fobh_pkg::OP_CORRECT_CPY: r_x  <= r_xn;
                    fobh_pkg::OP_INIT_IN, fobh_pkg::OP_INIT_OUT: r_x <= r_xn;
                    default: ;
                endcase
            end
            if (i_cmd.out_load) begin
                r_out.out_value   <= r_y;
                r_out.state_value <= r_xn;
                r_out.div_error   <= r_err;
            end
        end
    end

    always_comb begin
        o_sts.opcode   = r_in.opcode;
        o_sts.a_zero   = (r_a == '0);
        o_sts.b_zero   = (r_b == '0);
        o_sts.den_zero = (r_acc == '0);
        o_sts.div_done = div_done;
    end
    assign o_word = r_out;
endmodule

// ===== rtl/core/fobh_ctrl.sv =====
// controller: sequences multiplier, adder and divider steps per opcode
module fobh_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    input  fobh_pkg::t_sts  i_sts,
    output fobh_pkg::t_cmd  o_cmd
);
    // micro step list, one entry per multiplier or adder action
    typedef struct packed {
        logic              is_mul;
        fobh_pkg::t_mul_sel m;
        fobh_pkg::t_add_sel a;
    } t_uop;

    fobh_pkg::t_state r_state, n_state;
    logic [3:0] r_pc, n_pc;
    logic       r_ov, n_ov;
    logic       r_div2, n_div2;
    t_uop       uop;
    logic       last;

    // step programs
    always_comb begin
        uop  = '{1'b0, fobh_pkg::MS_AX, fobh_pkg::AS_DEN};
        last = 1'b1;
        unique case (i_sts.opcode)
            fobh_pkg::OP_PREDICT, fobh_pkg::OP_CORRECT: begin
                last = 1'b0;
                unique case (r_pc)
                    4'd0: uop = '{1'b1, fobh_pkg::MS_AX, fobh_pkg::AS_NONE};
                    4'd1: uop = '{1'b0, fobh_pkg::MS_AX, fobh_pkg::AS_NONE};
                    4'd2: uop = '{1'b1, fobh_pkg::MS_BU, fobh_pkg::AS_NONE};
                    4'd3: uop = '{1'b0, fobh_pkg::MS_AX, fobh_pkg::AS_SLOPE};
                    4'd4: uop = '{1'b0, fobh_pkg::MS_AX,
                        i_sts.opcode == fobh_pkg::OP_PREDICT ? fobh_pkg::AS_PRED
                                                             : fobh_pkg::AS_CORR_SUM};
                    4'd5: uop = '{1'b1, fobh_pkg::MS_DTD, fobh_pkg::AS_NONE};
                    4'd6: uop = '{1'b0, fobh_pkg::MS_AX, fobh_pkg::AS_CORR};
                    4'd7: uop = '{1'b1, fobh_pkg::MS_DU, fobh_pkg::AS_NONE};
                    default: begin
                        uop = '{1'b0, fobh_pkg::MS_AX, fobh_pkg::AS_OUT};
                        last = 1'b1;
                    end
                endcase
            end
            fobh_pkg::OP_INIT_IN: begin
                if (i_sts.a_zero || i_sts.b_zero) begin
                    last = (r_pc == 4'd1);
                    uop = (r_pc == 4'd0) ? '{1'b1, fobh_pkg::MS_DU, fobh_pkg::AS_NONE}
                                         : '{1'b0, fobh_pkg::MS_AX, fobh_pkg::AS_DEN};
                end else begin
                    last = (r_pc == 4'd3);
                    unique case (r_pc)
                        4'd0: uop = '{1'b1, fobh_pkg::MS_NRU, fobh_pkg::AS_NONE};
                        4'd1: uop = '{1'b0, fobh_pkg::MS_AX, fobh_pkg::AS_STATE_IN};
                        4'd2: uop = '{1'b1, fobh_pkg::MS_DU, fobh_pkg::AS_NONE};
                        default: uop = '{1'b0, fobh_pkg::MS_AX, fobh_pkg::AS_Y_IN};
                    endcase
                end
            end
            fobh_pkg::OP_INIT_OUT: begin
                if (!i_sts.a_zero) begin
                    last = (r_pc == 4'd1);
                    uop = (r_pc == 4'd0) ? '{1'b1, fobh_pkg::MS_NRY, fobh_pkg::AS_NONE}
                                         : '{1'b0, fobh_pkg::MS_AX, fobh_pkg::AS_STATE_OUT};
                end
            end
            // copies and queries: pick the state, then form the clamped output
            default: begin
                last = (r_pc == 4'd2);
                unique case (r_pc)
                    4'd0: uop = '{1'b0, fobh_pkg::MS_AX, fobh_pkg::AS_DEN};
                    4'd1: uop = '{1'b1, fobh_pkg::MS_DU, fobh_pkg::AS_NONE};
                    default: uop = '{1'b0, fobh_pkg::MS_AX, fobh_pkg::AS_OUT};
                endcase
            end
        endcase
    end

    logic need_div;
    assign need_div = (i_sts.opcode == fobh_pkg::OP_INIT_IN && !i_sts.a_zero && !i_sts.b_zero)
                   || (i_sts.opcode == fobh_pkg::OP_INIT_OUT && !i_sts.a_zero);

    logic out_free;
    assign out_free = !r_ov || !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        n_div2  = r_div2;
        n_ov    = r_ov && i_out_stall;
        unique case (r_state)
            fobh_pkg::ST_IDLE:   if (i_in_valid) n_state = fobh_pkg::ST_DECODE;
            fobh_pkg::ST_DECODE: begin
                n_pc   = '0;
                n_div2 = 1'b0;
                n_state = need_div ? fobh_pkg::ST_DIV_START : fobh_pkg::ST_MUL;
            end
            fobh_pkg::ST_DIV_START: n_state = fobh_pkg::ST_DIV_WAIT;
            fobh_pkg::ST_DIV_WAIT:  if (i_sts.div_done) n_state = fobh_pkg::ST_DIV_POST;
            fobh_pkg::ST_DIV_POST: begin
                if (i_sts.opcode == fobh_pkg::OP_INIT_OUT && !r_div2) begin
                    n_div2 = 1'b1;
                    n_state = fobh_pkg::ST_ADD;
                end else begin
                    n_state = fobh_pkg::ST_MUL;
                end
            end
            fobh_pkg::ST_ADD: begin
                // divisor check between the two divides
                n_state = i_sts.den_zero ? fobh_pkg::ST_MUL : fobh_pkg::ST_DIV_START;
            end
            fobh_pkg::ST_MUL: begin
                n_pc = r_pc + 1'b1;
                if (last) n_state = fobh_pkg::ST_FINISH;
            end
            fobh_pkg::ST_FINISH: if (out_free) n_state = fobh_pkg::ST_OUT;
            fobh_pkg::ST_OUT: begin
                n_ov = 1'b1;
                n_state = fobh_pkg::ST_IDLE;
            end
            default: n_state = fobh_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd = '0;
        o_cmd.mul_sel = uop.m;
        o_cmd.add_sel = uop.a;
        o_cmd.div_sel = r_div2 ? fobh_pkg::DS_UDEN : fobh_pkg::DS_BA;
        o_in_stall = (r_state != fobh_pkg::ST_IDLE);
        unique case (r_state)
            fobh_pkg::ST_IDLE:      o_cmd.load = i_in_valid;
            fobh_pkg::ST_DIV_START: o_cmd.div_go = 1'b1;
            fobh_pkg::ST_DIV_POST:  o_cmd.div_post = 1'b1;
            fobh_pkg::ST_ADD: begin
                if (i_sts.den_zero) begin
                    o_cmd.add_go  = 1'b1;
                    o_cmd.add_sel = fobh_pkg::AS_NEGR;
                end
            end
            fobh_pkg::ST_MUL: begin
                o_cmd.mul_go = uop.is_mul;
                o_cmd.add_go = !uop.is_mul;
            end
            fobh_pkg::ST_FINISH: o_cmd.commit = out_free;
            fobh_pkg::ST_OUT:    o_cmd.out_load = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fobh_pkg::ST_IDLE;
            r_pc    <= '0;
            r_ov    <= 1'b0;
            r_div2  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_ov    <= n_ov;
            r_div2  <= n_div2;
        end
    end

    assign o_out_valid = r_ov;
endmodule

// ===== rtl/core/first_order_block_heun_step_core.sv =====
// first-order state-space block stepped by heun predictor-corrector integration
// init from input divides only when a and b are both nonzero, init from output only when a
// is nonzero, and a second time unless the first divide leaves a zero divisor
// each 48-step serial divide sets the pace of both init opcodes
// throughput: one word at a time; the next word can be taken once the result turns valid,
// and a word that finishes while the previous result is still stalled waits to commit
// reset: synchronous active low; state cleared, slope limits to +/-1000.0
module first_order_block_heun_step_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  fobh_pkg::t_in_word   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output fobh_pkg::t_out_word  o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [2:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data
);
    fobh_pkg::t_cmd cmd;
    fobh_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    fobh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    fobh_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_word      (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_word      (o_out_data)
    );
endmodule

// ===== rtl/core/fobh_checker.sv =====
// port-level checker for the heun step core, bound to the top level
module fobh_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input fobh_pkg::t_out_word o_out_data
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second word taken while busy");

    a_err_only_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.div_error |-> o_out_data.out_value == 32'sh7fff_ffff
            || o_out_data.out_value == 32'sh8000_0000 || o_out_data.out_value == 32'sd0)
        else $error("divide error with unsaturated value");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");
endmodule

bind first_order_block_heun_step_core fobh_checker u_fobh_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// ===== verif/tb_top.sv =====
// self-checking testbench for the heun step core: predictor, random stimulus, stall pressure
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam logic [30:0] DT_MAX = 31'h7fff_ffff;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    fobh_pkg::t_in_word i_in_data = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    fobh_pkg::t_out_word o_out_data;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [2:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    first_order_block_heun_step_core u_dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // predictor state
    logic signed [31:0] m_a, m_b, m_d, m_slo, m_shi;
    logic signed [31:0] m_x, m_px, m_ps;
    logic m_stage;

    fobh_pkg::t_out_word expected_words[$];
    int errors = 0;
    int cycles = 0;
    bit hold_rx = 0;
    bit rx_random = 1;

    function automatic logic signed [31:0] sat(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7fff_ffff;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] lim(input logic signed [31:0] v,
            input logic signed [31:0] lo, input logic signed [31:0] hi);
        logic signed [31:0] r;
        r = (v > hi) ? hi : v;
        if (r < lo) r = lo;
        return r;
    endfunction

    // arithmetic shift floors, matching truncation toward minus infinity
    function automatic logic signed [31:0] fmul(input logic signed [63:0] a,
            input logic signed [63:0] b);
        logic signed [63:0] p;
        p = a * b;
        return sat(p >>> fobh_pkg::FRAC_BITS);
    endfunction

    function automatic logic signed [31:0] fdiv(input logic signed [63:0] a,
            input logic signed [63:0] b);
        logic signed [63:0] n;
        n = a <<< fobh_pkg::FRAC_BITS;
        return sat(n / b);
    endfunction

    function automatic logic signed [31:0] slope(input logic signed [31:0] x,
            input logic signed [31:0] u);
        logic signed [63:0] s;
        s = 64'(fmul(m_a, x)) + 64'(fmul(m_b, u));
        return sat(s);
    endfunction

    function automatic fobh_pkg::t_out_word heun_step(input fobh_pkg::t_in_word w);
        fobh_pkg::t_out_word r;
        logic signed [31:0] xn, d, nr, rr, den, y;
        logic signed [63:0] s;
        r = '0;
        case (fobh_pkg::t_opcode'(w.opcode))
            fobh_pkg::OP_PREDICT: begin
                d = lim(slope(m_x, w.in_value), m_slo, m_shi);
                m_ps = d;
                m_px = lim(sat(64'(m_x) + 64'(fmul({33'd0, w.step_time}, d))),
                    w.x_low, w.x_high);
                m_stage = 1;
                xn = m_px;
            end
            fobh_pkg::OP_CORRECT: begin
                s = 64'(m_ps) + 64'(slope(m_px, w.in_value));
                d = sat(s >>> 1);
                d = lim(d, m_slo, m_shi);
                m_x = lim(sat(64'(m_x) + 64'(fmul({33'd0, w.step_time}, d))),
                    w.x_low, w.x_high);
                m_stage = 0;
                xn = m_x;
            end
            fobh_pkg::OP_PREDICT_CPY: begin
                m_px = m_x;
                xn = m_px;
            end
            fobh_pkg::OP_CORRECT_CPY: begin
                m_x = m_px;
                xn = m_x;
            end
            fobh_pkg::OP_INIT_IN: begin
                if (m_a == 0 || m_b == 0) begin
                    m_x = 0;
                    y = fmul(m_d, w.in_value);
                end else begin
                    nr = sat(-64'(fdiv(m_b, m_a)));
                    m_x = fmul(nr, w.in_value);
                    y = sat(64'(m_x) + 64'(fmul(m_d, w.in_value)));
                end
                r.out_value = y;
                r.state_value = m_x;
                return r;
            end
            fobh_pkg::OP_INIT_OUT: begin
                if (m_a == 0) begin
                    y = 0;
                    m_x = w.in_value;
                end else begin
                    rr = fdiv(m_b, m_a);
                    nr = sat(-64'(rr));
                    den = sat(64'(m_d) - 64'(rr));
                    if (den == 0) begin
                        r.div_error = 1;
                        y = (w.in_value > 0) ? 32'sh7fff_ffff :
                            (w.in_value < 0) ? 32'sh8000_0000 : 32'sd0;
                    end else begin
                        y = fdiv(w.in_value, den);
                    end
                    m_x = fmul(nr, y);
                end
                r.out_value = y;
                r.state_value = m_x;
                return r;
            end
            default: xn = m_stage ? m_px : m_x;
        endcase
        r.out_value = lim(sat(64'(xn) + 64'(fmul(m_d, w.in_value))), w.y_low, w.y_high);
        r.state_value = xn;
        return r;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL first_order_block_heun_step_core");
            $finish;
        end
    end

    // receiver: random stall per word plus optional long hold-off
    int rx_wait = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_words.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
            end else begin
                fobh_pkg::t_out_word e;
                e = expected_words.pop_front();
                if (o_out_data.out_value !== e.out_value) begin
                    $error("out_value exp %0d got %0d", e.out_value, o_out_data.out_value);
                    errors++;
                end
                if (o_out_data.state_value !== e.state_value) begin
                    $error("state_value exp %0d got %0d", e.state_value,
                        o_out_data.state_value);
                    errors++;
                end
                if (o_out_data.div_error !== e.div_error) begin
                    $error("div_error exp %0d got %0d", e.div_error, o_out_data.div_error);
                    errors++;
                end
            end
            rx_wait <= rx_random && ($urandom_range(0, 2) == 0) ? $urandom_range(0, 13) : 0;
            i_out_stall <= 1'b1;
        end else if (hold_rx) begin
            i_out_stall <= 1'b1;
        end else if (rx_wait > 0) begin
            rx_wait <= rx_wait - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    bit tx_random = 1;

    // valid stays up after an accept; whoever waits next drops it
    task automatic send_word(input fobh_pkg::t_in_word w);
        int gap;
        gap = (tx_random && $urandom_range(0, 2) == 0) ? $urandom_range(0, 13) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_data <= w;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        expected_words.push_back(heun_step(w));
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    task automatic write_reg(input fobh_pkg::t_cfg_index idx, input logic signed [31:0] v);
        i_cfg_index <= idx;
        i_cfg_data <= v;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            fobh_pkg::CFG_COEF_STATE: m_a = v;
            fobh_pkg::CFG_COEF_INPUT: m_b = v;
            fobh_pkg::CFG_COEF_FEED:  m_d = v;
            fobh_pkg::CFG_SLOPE_LOW:  m_slo = v;
            default:                  m_shi = v;
        endcase
    endtask

    task automatic set_all(input logic signed [31:0] a, b, d, lo, hi);
        drain();
        write_reg(fobh_pkg::CFG_COEF_STATE, a);
        write_reg(fobh_pkg::CFG_COEF_INPUT, b);
        write_reg(fobh_pkg::CFG_COEF_FEED, d);
        write_reg(fobh_pkg::CFG_SLOPE_LOW, lo);
        write_reg(fobh_pkg::CFG_SLOPE_HIGH, hi);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [31:0] rnd_q();
        case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return $signed($urandom_range(0, 2 * 65536 * 20)) - 32'sd1310720;
            default: return $urandom;
        endcase
    endfunction

    function automatic fobh_pkg::t_in_word mk(input fobh_pkg::t_opcode op,
            input logic signed [31:0] u, input logic [30:0] dt,
            input logic signed [31:0] xl, xh, yl, yh);
        fobh_pkg::t_in_word w;
        w.opcode = op;
        w.in_value = u;
        w.step_time = dt;
        w.x_low = xl;
        w.x_high = xh;
        w.y_low = yl;
        w.y_high = yh;
        return w;
    endfunction

    // random word: mostly wide-open clamps so integration moves freely
    function automatic fobh_pkg::t_in_word rnd_word(input fobh_pkg::t_opcode op);
        logic signed [31:0] a, b;
        fobh_pkg::t_in_word w;
        w = mk(op, rnd_q(), ($urandom_range(0, 9) == 0) ? 31'($urandom) :
            31'($urandom_range(0, 65536)), 32'sh8000_0000, 32'sh7fff_ffff,
            32'sh8000_0000, 32'sh7fff_ffff);
        if ($urandom_range(0, 3) == 0) begin
            a = rnd_q(); b = rnd_q();
            w.x_low = a; w.x_high = b;
            a = rnd_q(); b = rnd_q();
            w.y_low = a; w.y_high = b;
        end
        return w;
    endfunction

    task automatic test_directed();
        fobh_pkg::t_opcode op;
        send_word(mk(fobh_pkg::OP_QUERY6, 32'sd65536, 31'd0, 32'sh8000_0000, 32'sh7fff_ffff,
            32'sh8000_0000, 32'sh7fff_ffff));
        set_all(-32'sd32768, 32'sd131072, 32'sd16384, -32'sd65536000, 32'sd65536000);
        for (int i = 0; i < 8; i++) begin
            op = fobh_pkg::t_opcode'(i);
            send_word(mk(op, 32'sd196608, 31'd6554, 32'sh8000_0000, 32'sh7fff_ffff,
                32'sh8000_0000, 32'sh7fff_ffff));
        end
        // extremes, inverted clamps, maximal step
        send_word(mk(fobh_pkg::OP_PREDICT, 32'sh7fff_ffff, DT_MAX, 32'sd10, -32'sd10,
            32'sh7fff_ffff, 32'sh8000_0000));
        send_word(mk(fobh_pkg::OP_CORRECT, 32'sh8000_0000, DT_MAX, 32'sh8000_0000,
            32'sh7fff_ffff, -32'sd5, 32'sd5));
        send_word(mk(fobh_pkg::OP_QUERY7, 32'sh8000_0000, DT_MAX, 32'sh7fff_ffff,
            32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff));
        send_word(mk(fobh_pkg::OP_INIT_IN, 32'sh7fff_ffff, 31'd0, '0, '0, '0, '0));
        send_word(mk(fobh_pkg::OP_INIT_OUT, 32'sh8000_0000, 31'd0, '0, '0, '0, '0));
        // zero divisor: D equal to B/A (B/A = -4, so D = -4)
        set_all(-32'sd32768, 32'sd131072, -32'sd262144, 32'sh8000_0000, 32'sh7fff_ffff);
        send_word(mk(fobh_pkg::OP_INIT_OUT, 32'sd65536, 31'd0, '0, '0, '0, '0));
        send_word(mk(fobh_pkg::OP_INIT_OUT, -32'sd65536, 31'd0, '0, '0, '0, '0));
        send_word(mk(fobh_pkg::OP_INIT_OUT, 32'sd0, 31'd0, '0, '0, '0, '0));
        // B zero and A zero paths of the inits
        set_all(32'sd0, 32'sd0, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000);
        send_word(mk(fobh_pkg::OP_INIT_IN, 32'sd12345678, 31'd0, '0, '0, '0, '0));
        send_word(mk(fobh_pkg::OP_INIT_OUT, -32'sd777, 31'd0, '0, '0, '0, '0));
        send_word(mk(fobh_pkg::OP_PREDICT, 32'sd1, 31'd65536, 32'sh8000_0000, 32'sh7fff_ffff,
            32'sh8000_0000, 32'sh7fff_ffff));
    endtask

    task automatic test_random(input int n);
        fobh_pkg::t_opcode op;
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 19);
            if (r < 14) begin
                // well-formed predict/correct pair
                send_word(rnd_word(fobh_pkg::OP_PREDICT));
                send_word(rnd_word(fobh_pkg::OP_CORRECT));
                i++;
            end else begin
                op = fobh_pkg::t_opcode'($urandom_range(0, 7));
                send_word(rnd_word(op));
            end
        end
    endtask

    task automatic test_config_sweeps();
        for (int k = 0; k < 4; k++) begin
            set_all(rnd_q(), rnd_q(), rnd_q(), -32'sd65536 * $urandom_range(1, 2000),
                32'sd65536 * $urandom_range(1, 2000));
            test_random(40);
        end
        set_all(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000,
            32'sh7fff_ffff);
        test_random(30);
        set_all(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff,
            32'sh8000_0000);
        test_random(30);
    endtask

    task automatic test_pressure();
        set_all(-32'sd6554, 32'sd65536, 32'sd3277, -32'sd655360, 32'sd655360);
        // long receiver hold-off, counted in its own process
        fork
            begin
                hold_rx <= 1'b1;
                repeat (400) @(posedge i_clk);
                hold_rx <= 1'b0;
            end
        join_none
        for (int i = 0; i < 10; i++) send_word(rnd_word(fobh_pkg::OP_PREDICT));
        // sender waits until everything came back
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        tx_random = 0;
        rx_random = 0;
        test_random(40);
        tx_random = 1;
        rx_random = 1;
    endtask

    initial begin
        m_a = 0; m_b = 0; m_d = 0;
        m_slo = fobh_pkg::SLOPE_LOW_RST; m_shi = fobh_pkg::SLOPE_HIGH_RST;
        m_x = 0; m_px = 0; m_ps = 0; m_stage = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_pressure();
        set_all(-32'sd16384, 32'sd65536, 32'sd0, -32'sd65536000, 32'sd65536000);
        test_random(250);
        test_config_sweeps();
        drain();
        if (errors == 0) begin
            $display("PASS first_order_block_heun_step_core");
        end else begin
            $display("FAIL first_order_block_heun_step_core");
        end
        $finish;
    end
endmodule
